// File: src/assert_macros.svh
// Assertion macros shared by the calendar date arithmetic RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CDAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CDAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cdau_pkg.sv
// Package for the calendar date arithmetic unit: modes, controller states,
// command/status structs and Gregorian calendar helper functions. No dependencies.
`timescale 1ns / 1ps

package cdau_pkg;

    localparam int YEAR_W = 16;
    localparam int YEAR_CYCLE = 400;
    localparam int YEAR_LIMIT = 9999;

    localparam logic [2:0] MODE_CHECK = 3'd0;
    localparam logic [2:0] MODE_NEXT  = 3'd1;
    localparam logic [2:0] MODE_PREV  = 3'd2;
    localparam logic [2:0] MODE_ADD   = 3'd3;
    localparam logic [2:0] MODE_SUB   = 3'd4;
    localparam logic [2:0] MODE_AGE   = 3'd5;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };
    localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_WALK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic load_ymod;
        logic check;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic date_ok;
        logic shift_op;
        logic more;
        logic out_free;
    } t_dp_stat;

    // year modulo 400 by six conditional subtractions
    function automatic logic [8:0] year_mod400(input logic [13:0] y);
        logic [13:0] r;
        r = y;
        for (int k = 5; k >= 0; k--) begin
            if (r >= 14'(YEAR_CYCLE << k)) begin
                r = r - 14'(YEAR_CYCLE << k);
            end
        end
        return r[8:0];
    endfunction

    function automatic logic is_leap(input logic [8:0] ymod);
        return (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200)
            && (ymod != 9'd300);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        if (m == MONTH_FEB && leap) begin
            return FEB_LEAP_LEN;
        end
        return MONTH_LEN[m];
    endfunction

endpackage

// File: src/cdau_ctrl.sv
// Controller of the calendar date arithmetic unit: sequences load, check,
// month walk and output. Depends on cdau_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdau_ctrl
    import cdau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = (i_stat.date_ok && i_stat.shift_op) ? S_WALK : S_FINISH;
            end
            S_WALK: begin
                if (!i_stat.more) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_LOAD: begin
                o_cmd.load_ymod = 1'b1;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
            end
            S_WALK: begin
                o_cmd.step = i_stat.more;
            end
            S_FINISH: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    `CDAU_ASSERT_NEXT(a_capture_load, i_clk, i_rst_n, o_cmd.capture, r_state == S_LOAD, "capture did not move to load")
    `CDAU_ASSERT_NEXT(a_walk_end, i_clk, i_rst_n, (r_state == S_WALK) && !i_stat.more, r_state == S_FINISH, "walk end did not move to finish")

endmodule

// File: src/cdau_dp.sv
// Datapath of the calendar date arithmetic unit: item registers, validation,
// month-by-month walk, age and output register. Depends on cdau_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdau_dp
    import cdau_pkg::*;
#(
    parameter int MAX_SHIFT_DAYS = 4095
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [13:0]        i_cfg_wr_data,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [2:0]         i_mode,
    input  logic [4:0]         i_day,
    input  logic [3:0]         i_month,
    input  logic [13:0]        i_year,
    input  logic [11:0]        i_day_count,
    input  logic [4:0]         i_ref_day,
    input  logic [3:0]         i_ref_month,
    input  logic [13:0]        i_ref_year,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [4:0]         o_res_day,
    output logic [3:0]         o_res_month,
    output logic [13:0]        o_res_year,
    output logic signed [14:0] o_age_years,
    output logic               o_date_valid,
    output logic               o_out_of_range
);

    localparam int DW = $clog2(MAX_SHIFT_DAYS + 32) + 1;

    logic [13:0]              r_base;
    logic [2:0]               r_mode;
    logic signed [DW-1:0]     r_day;
    logic [3:0]               r_month;
    logic signed [YEAR_W-1:0] r_year;
    logic [8:0]               r_ymod;
    logic signed [DW-1:0]     r_n;
    logic [4:0]               r_ref_day;
    logic [3:0]               r_ref_month;
    logic [13:0]              r_ref_year;
    logic [14:0]              r_age;
    logic                     r_valid;

    logic                     r_o_valid;
    logic [4:0]               r_o_day;
    logic [3:0]               r_o_month;
    logic [13:0]              r_o_year;
    logic [14:0]              r_o_age;
    logic                     r_o_date_valid;
    logic                     r_o_oor;

    logic                     fwd;
    logic [4:0]               md_cur;
    logic signed [DW-1:0]     md_cur_s;
    logic [8:0]               ymod_inc;
    logic [8:0]               ymod_dec;
    logic [3:0]               m_prev;
    logic [8:0]               ymod_prev;
    logic signed [DW-1:0]     md_prev_s;
    logic signed [DW-1:0]     offset;
    logic                     ref_before;
    logic signed [YEAR_W-1:0] age_diff;

    always_comb begin
        fwd = (r_mode == MODE_NEXT) || (r_mode == MODE_ADD);
        md_cur = month_days(r_month, is_leap(r_ymod));
        md_cur_s = signed'(DW'(md_cur));
        ymod_inc = (r_ymod == 9'(YEAR_CYCLE - 1)) ? 9'd0 : r_ymod + 9'd1;
        ymod_dec = (r_ymod == 9'd0) ? 9'(YEAR_CYCLE - 1) : r_ymod - 9'd1;
        m_prev = (r_month == MONTH_JAN) ? MONTH_DEC : r_month - 4'd1;
        ymod_prev = (r_month == MONTH_JAN) ? ymod_dec : r_ymod;
        md_prev_s = signed'(DW'(month_days(m_prev, is_leap(ymod_prev))));
        offset = ((r_mode == MODE_NEXT) || (r_mode == MODE_PREV)) ? DW'(1) : r_n;
        ref_before = (r_ref_month < r_month)
            || ((r_ref_month == r_month) && (DW'(r_ref_day) < r_day));
        age_diff = signed'(YEAR_W'(r_ref_year)) - r_year
            - (ref_before ? YEAR_W'(1) : YEAR_W'(0));

        o_stat.date_ok = (r_year[13:0] >= r_base) && (r_month >= MONTH_JAN)
            && (r_month <= MONTH_DEC) && (r_day >= DW'(1)) && (r_day <= md_cur_s);
        o_stat.shift_op = fwd || (r_mode == MODE_PREV) || (r_mode == MODE_SUB);
        o_stat.more = fwd ? (r_day > md_cur_s) : (r_day <= signed'(DW'(0)));
        o_stat.out_free = !r_o_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 14'd1900;
        end else if (i_cfg_wr_en) begin
            r_base <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_day <= DW'(i_day);
            r_month <= i_month;
            r_year <= YEAR_W'(i_year);
            r_n <= (int'(i_day_count) > MAX_SHIFT_DAYS) ? DW'(MAX_SHIFT_DAYS)
                                                        : DW'(i_day_count);
            r_ref_day <= i_ref_day;
            r_ref_month <= i_ref_month;
            r_ref_year <= i_ref_year;
            r_age <= '0;
            r_valid <= 1'b0;
        end else if (i_cmd.load_ymod) begin
            r_ymod <= year_mod400(r_year[13:0]);
        end else if (i_cmd.check) begin
            r_valid <= o_stat.date_ok;
            if (o_stat.date_ok) begin
                if (r_mode == MODE_AGE) begin
                    r_age <= age_diff[14:0];
                end else if (o_stat.shift_op) begin
                    r_day <= fwd ? r_day + offset : r_day - offset;
                end
            end
        end else if (i_cmd.step) begin
            if (fwd) begin
                r_day <= r_day - md_cur_s;
                if (r_month == MONTH_DEC) begin
                    r_month <= MONTH_JAN;
                    r_year <= r_year + YEAR_W'(1);
                    r_ymod <= ymod_inc;
                end else begin
                    r_month <= r_month + 4'd1;
                end
            end else begin
                r_day <= r_day + md_prev_s;
                r_month <= m_prev;
                r_ymod <= ymod_prev;
                if (r_month == MONTH_JAN) begin
                    r_year <= r_year - YEAR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_day <= r_day[4:0];
            r_o_month <= r_month;
            r_o_age <= r_age;
            r_o_date_valid <= r_valid;
            if (r_valid && (r_year > signed'(YEAR_W'(YEAR_LIMIT)))) begin
                r_o_oor <= 1'b1;
                r_o_year <= 14'(YEAR_LIMIT);
            end else if (r_valid && (r_year < signed'(YEAR_W'(0)))) begin
                r_o_oor <= 1'b1;
                r_o_year <= 14'd0;
            end else begin
                r_o_oor <= 1'b0;
                r_o_year <= r_year[13:0];
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_res_day = r_o_day;
    assign o_res_month = r_o_month;
    assign o_res_year = r_o_year;
    assign o_age_years = signed'(r_o_age);
    assign o_date_valid = r_o_date_valid;
    assign o_out_of_range = r_o_oor;

    `CDAU_ASSERT_IMPLY(a_step_month, i_clk, i_rst_n, i_cmd.step,
        r_valid && (r_month >= MONTH_JAN) && (r_month <= MONTH_DEC),
        "walk step on an unchecked date")
    `CDAU_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, i_cmd.emit, r_o_valid,
        "emitted word not presented")
    `CDAU_ASSERT_IMPLY(a_oor_valid, i_clk, i_rst_n, r_o_valid && r_o_oor, r_o_date_valid,
        "range flag on an invalid date")

endmodule

// File: src/calendar_date_arithmetic_unit.sv
// Calendar date arithmetic unit, top level: controller plus datapath.
// Depends on cdau_pkg, cdau_ctrl and cdau_dp.
//
// One input word at a time. An item passes through accept, year-cycle load,
// check and output for check, age and invalid dates; next, previous, add and
// subtract also walk between check and output over each month boundary
// crossed, and the walk handles one month per cycle. Results wait in an output
// register; a held output only delays the next item at its output cycle.
// base_year resets to 1900.
`timescale 1ns / 1ps

module calendar_date_arithmetic_unit
    import cdau_pkg::*;
#(
    parameter int MAX_SHIFT_DAYS = 4095
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [13:0]        i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_mode,
    input  logic [4:0]         i_day,
    input  logic [3:0]         i_month,
    input  logic [13:0]        i_year,
    input  logic [11:0]        i_day_count,
    input  logic [4:0]         i_ref_day,
    input  logic [3:0]         i_ref_month,
    input  logic [13:0]        i_ref_year,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [4:0]         o_res_day,
    output logic [3:0]         o_res_month,
    output logic [13:0]        o_res_year,
    output logic signed [14:0] o_age_years,
    output logic               o_date_valid,
    output logic               o_out_of_range
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    cdau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cdau_dp #(
        .MAX_SHIFT_DAYS (MAX_SHIFT_DAYS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (i_mode),
        .i_day          (i_day),
        .i_month        (i_month),
        .i_year         (i_year),
        .i_day_count    (i_day_count),
        .i_ref_day      (i_ref_day),
        .i_ref_month    (i_ref_month),
        .i_ref_year     (i_ref_year),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_res_day      (o_res_day),
        .o_res_month    (o_res_month),
        .o_res_year     (o_res_year),
        .o_age_years    (o_age_years),
        .o_date_valid   (o_date_valid),
        .o_out_of_range (o_out_of_range)
    );

endmodule

// File: dv/testbench.sv
// Testbench for calendar_date_arithmetic_unit: directed and random date words checked
// field by field against a date predictor, with random input gaps and output stalls.
// Depends on cdau_pkg and the RTL top level.
`timescale 1ns / 1ps

module testbench
    import cdau_pkg::*;
();

    localparam int YEAR_MAX = 9999;
    localparam int MAX_SHIFT = 4095;
    localparam int DRAIN_CYCLES = 200;
    localparam int LIMIT_NS = 8_000_000;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [11:0] day_count;
        logic [4:0]  ref_day;
        logic [3:0]  ref_month;
        logic [13:0] ref_year;
    } t_date_word;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [14:0] age;
        logic        valid;
        logic        oor;
    } t_date_result;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [13:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  mode = '0;
    logic [4:0]  day = 5'd1;
    logic [3:0]  month = 4'd1;
    logic [13:0] year = '0;
    logic [11:0] day_count = '0;
    logic [4:0]  ref_day = 5'd1;
    logic [3:0]  ref_month = 4'd1;
    logic [13:0] ref_year = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  res_day;
    logic [3:0]  res_month;
    logic [13:0] res_year;
    logic signed [14:0] age_years;
    logic        date_valid;
    logic        out_of_range;

    t_date_result expected_dates[$];
    int base_year_q = 1900;
    int errors = 0;
    bit tx_idle = 1'b1;
    bit rx_random = 1'b1;
    int rx_hold_req = 0;

    calendar_date_arithmetic_unit DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_mode         (mode),
        .i_day          (day),
        .i_month        (month),
        .i_year         (year),
        .i_day_count    (day_count),
        .i_ref_day      (ref_day),
        .i_ref_month    (ref_month),
        .i_ref_year     (ref_year),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_res_day      (res_day),
        .o_res_month    (res_month),
        .o_res_year     (res_year),
        .o_age_years    (age_years),
        .o_date_valid   (date_valid),
        .o_out_of_range (out_of_range)
    );

    always #2 clk = ~clk;

    initial begin
        #(LIMIT_NS);
        $display("calendar_date_arithmetic_unit verification failed");
        $finish;
    end

    function automatic bit leap_year(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in_month(int m, int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic t_date_result predict_date(t_date_word w);
        t_date_result r;
        int d, m, y, n, rd, rm, ry, age;
        bit ok;
        d = int'(w.day);
        m = int'(w.month);
        y = int'(w.year);
        n = int'(w.day_count);
        rd = int'(w.ref_day);
        rm = int'(w.ref_month);
        ry = int'(w.ref_year);
        age = 0;
        r.oor = 1'b0;
        if (n > MAX_SHIFT) n = MAX_SHIFT;
        ok = (y >= base_year_q) && (m >= 1) && (m <= 12) && (d >= 1)
            && (d <= days_in_month(m, y));
        if (ok) begin
            case (w.mode)
                MODE_NEXT, MODE_ADD: begin
                    d += (w.mode == MODE_NEXT) ? 1 : n;
                    while (d > days_in_month(m, y)) begin
                        d -= days_in_month(m, y);
                        m++;
                        if (m > 12) begin
                            m = 1;
                            y++;
                        end
                    end
                end
                MODE_PREV, MODE_SUB: begin
                    d -= (w.mode == MODE_PREV) ? 1 : n;
                    while (d <= 0) begin
                        m--;
                        if (m < 1) begin
                            m = 12;
                            y--;
                        end
                        d += days_in_month(m, y);
                    end
                end
                MODE_AGE: begin
                    age = ry - y;
                    if (rm < m || (rm == m && rd < d)) age--;
                end
                default: ;
            endcase
            if (y > YEAR_MAX) begin
                r.oor = 1'b1;
                y = YEAR_MAX;
            end else if (y < 0) begin
                r.oor = 1'b1;
                y = 0;
            end
        end
        r.day = d[4:0];
        r.month = m[3:0];
        r.year = y[13:0];
        r.age = age[14:0];
        r.valid = ok;
        return r;
    endfunction

    function automatic t_date_word mk(logic [2:0] md, int d, int m, int y, int n,
                                      int rd, int rm, int ry);
        t_date_word w;
        w.mode = md;
        w.day = d[4:0];
        w.month = m[3:0];
        w.year = y[13:0];
        w.day_count = n[11:0];
        w.ref_day = rd[4:0];
        w.ref_month = rm[3:0];
        w.ref_year = ry[13:0];
        return w;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    function automatic t_date_word rand_word(int y_lo, int y_hi);
        t_date_word w;
        int r, len, y, ry;
        r = $urandom_range(0, 99);
        w.mode = (r < 4) ? 3'($urandom_range(MODE_SPARE_6, MODE_SPARE_7))
                         : 3'($urandom_range(MODE_CHECK, MODE_AGE));
        y = ($urandom_range(0, 99) < 85) ? $urandom_range(y_lo, y_hi)
                                         : $urandom_range(0, YEAR_MAX);
        w.year = y[13:0];
        w.month = ($urandom_range(0, 99) < 96) ? 4'($urandom_range(1, 12))
                                               : 4'($urandom_range(0, 15));
        len = days_in_month(int'(w.month), y);
        r = $urandom_range(0, 99);
        if (r < 2) w.day = 5'd0;
        else if (r < 10 || len == 0) w.day = 5'($urandom_range(1, 31));
        else if (r < 25) w.day = len[4:0];
        else if (r < 35) w.day = 5'd1;
        else w.day = 5'($urandom_range(1, len));
        r = $urandom_range(0, 99);
        if (r < 60) w.day_count = 12'($urandom_range(0, 60));
        else if (r < 85) w.day_count = 12'($urandom_range(0, 1000));
        else if (r < 95) w.day_count = 12'($urandom_range(0, MAX_SHIFT));
        else w.day_count = 12'($urandom_range(MAX_SHIFT - 31, MAX_SHIFT));
        ry = y + $urandom_range(0, 200) - 100;
        if (ry < 0) ry = 0;
        if (ry > YEAR_MAX) ry = YEAR_MAX;
        if ($urandom_range(0, 99) < 20) ry = $urandom_range(0, YEAR_MAX);
        w.ref_year = ry[13:0];
        if ($urandom_range(0, 99) < 30) begin
            w.ref_month = w.month;
            w.ref_day = 5'(int'(w.day) + $urandom_range(0, 2) - 1);
        end else begin
            w.ref_month = 4'($urandom_range(1, 12));
            w.ref_day = 5'($urandom_range(1, 31));
        end
        return w;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Leaves valid high after acceptance; the next call, a gap or a drain moves it.
    task automatic send_word(t_date_word w);
        @(negedge clk);
        mode = w.mode;
        day = w.day;
        month = w.month;
        year = w.year;
        day_count = w.day_count;
        ref_day = w.ref_day;
        ref_month = w.ref_month;
        ref_year = w.ref_year;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        expected_dates.push_back(predict_date(w));
    endtask

    task automatic idle_gap();
        int n;
        n = tx_idle ? idle_len() : 0;
        if (n > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_dates.size() != 0) @(posedge clk);
    endtask

    task automatic write_base_year(int v);
        drain();
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = v[13:0];
        @(negedge clk);
        cfg_wr_en = 1'b0;
        base_year_q = v;
    endtask

    task automatic run_random(int count, int y_lo, int y_hi);
        repeat (count) begin
            send_word(rand_word(y_lo, y_hi));
            idle_gap();
        end
    endtask

    task automatic send_list(t_date_word words[$]);
        foreach (words[i]) begin
            send_word(words[i]);
            idle_gap();
        end
    endtask

    task automatic test_directed();
        t_date_word words[$];
        words.push_back(mk(MODE_CHECK, 1, 1, 1900, 0, 1, 1, 0));
        words.push_back(mk(MODE_CHECK, 31, 12, 9999, 4095, 31, 12, 9999));
        words.push_back(mk(MODE_NEXT, 28, 2, 2000, 0, 1, 1, 2000));
        words.push_back(mk(MODE_NEXT, 28, 2, 1900, 0, 1, 1, 2000));
        words.push_back(mk(MODE_NEXT, 31, 12, 1999, 0, 1, 1, 2000));
        words.push_back(mk(MODE_PREV, 1, 3, 2000, 0, 1, 1, 2000));
        words.push_back(mk(MODE_PREV, 1, 1, 1901, 0, 1, 1, 2000));
        words.push_back(mk(MODE_ADD, 15, 7, 2024, 0, 1, 1, 2000));
        words.push_back(mk(MODE_ADD, 1, 1, 1900, 4095, 31, 12, 9999));
        words.push_back(mk(MODE_SUB, 31, 12, 9999, 4095, 1, 1, 0));
        words.push_back(mk(MODE_NEXT, 31, 12, 9999, 0, 1, 1, 0));
        words.push_back(mk(MODE_ADD, 25, 12, 9995, 4095, 1, 1, 0));
        words.push_back(mk(MODE_AGE, 15, 6, 1990, 0, 14, 6, 2020));
        words.push_back(mk(MODE_AGE, 15, 6, 1990, 0, 15, 6, 2020));
        words.push_back(mk(MODE_AGE, 15, 6, 1990, 0, 1, 5, 2020));
        words.push_back(mk(MODE_AGE, 31, 12, 9999, 0, 31, 2, 0));
        words.push_back(mk(MODE_ADD, 29, 2, 1900, 10, 1, 1, 2000));
        words.push_back(mk(MODE_NEXT, 31, 4, 2001, 0, 1, 1, 2000));
        words.push_back(mk(MODE_CHECK, 10, 0, 2001, 0, 1, 1, 2000));
        words.push_back(mk(MODE_ADD, 10, 15, 2001, 5, 1, 1, 2000));
        words.push_back(mk(MODE_SUB, 0, 5, 2001, 5, 1, 1, 2000));
        words.push_back(mk(MODE_AGE, 1, 1, 1899, 0, 1, 1, 2000));
        words.push_back(mk(MODE_SPARE_6, 10, 5, 2001, 100, 1, 1, 2000));
        words.push_back(mk(MODE_SPARE_7, 10, 5, 2001, 4095, 31, 12, 9999));
        words.push_back(mk(MODE_CHECK, 29, 2, 2000, 77, 1, 1, 1000));
        send_list(words);
    endtask

    task automatic test_random_default_base();
        run_random(700, 1900, 9999);
    endtask

    task automatic test_base_extremes();
        t_date_word floor_words[$];
        int b;
        write_base_year(0);
        floor_words.push_back(mk(MODE_PREV, 1, 1, 0, 0, 1, 1, 0));
        floor_words.push_back(mk(MODE_SUB, 1, 1, 5, 4095, 1, 1, 0));
        floor_words.push_back(mk(MODE_CHECK, 29, 2, 0, 0, 1, 1, 0));
        floor_words.push_back(mk(MODE_NEXT, 28, 2, 0, 0, 1, 1, 0));
        send_list(floor_words);
        run_random(250, 0, 40);
        write_base_year(YEAR_MAX);
        run_random(200, 9990, 9999);
        b = $urandom_range(1, 9998);
        write_base_year(b);
        run_random(250, b, 9999);
    endtask

    // Receiver holds off while the sender keeps offering, then the sender waits for a drain.
    task automatic test_fill_and_drain();
        write_base_year(1900);
        tx_idle = 1'b0;
        rx_hold_req = 400;
        run_random(40, 1900, 9999);
        drain();
        tx_idle = 1'b1;
        run_random(30, 1900, 9999);
    endtask

    task automatic test_open_channels();
        write_base_year(1583);
        tx_idle = 1'b0;
        rx_random = 1'b0;
        run_random(300, 1583, 9999);
        tx_idle = 1'b1;
        rx_random = 1'b1;
        run_random(100, 1583, 9999);
    endtask

    initial begin : drive_out_stall
        int run;
        int hold;
        bit level;
        run = 0;
        level = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_req > 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
                out_stall = 1'b1;
                repeat (hold - 1) @(negedge clk);
            end else if (!rx_random) begin
                out_stall = 1'b0;
            end else begin
                if (run == 0) begin
                    level = !level;
                    run = level ? idle_len() : $urandom_range(1, 10);
                    if (run == 0) run = 1;
                end
                out_stall = level;
                run--;
            end
        end
    end

    always @(posedge clk) begin : check_results
        t_date_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_dates.size() == 0) begin
                report_mismatch("word with no expectation, res_year", int'(res_year), 0);
            end else begin
                want = expected_dates.pop_front();
                if (res_day !== want.day)
                    report_mismatch("res_day", int'(res_day), int'(want.day));
                if (res_month !== want.month)
                    report_mismatch("res_month", int'(res_month), int'(want.month));
                if (res_year !== want.year)
                    report_mismatch("res_year", int'(res_year), int'(want.year));
                if (age_years !== want.age)
                    report_mismatch("age_years", int'(age_years), int'($signed(want.age)));
                if (date_valid !== want.valid)
                    report_mismatch("date_valid", int'(date_valid), int'(want.valid));
                if (out_of_range !== want.oor)
                    report_mismatch("out_of_range", int'(out_of_range), int'(want.oor));
            end
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_default_base();
        test_base_extremes();
        test_fill_and_drain();
        test_open_channels();
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("calendar_date_arithmetic_unit verification clean");
        end else begin
            $display("calendar_date_arithmetic_unit verification failed");
        end
        $finish;
    end

endmodule

// File: calendar_date_arithmetic_unit.f
+incdir+src
src/cdau_pkg.sv
src/cdau_ctrl.sv
src/cdau_dp.sv
src/calendar_date_arithmetic_unit.sv
dv/testbench.sv
